FILE: hdl/pce_pkg.sv
// Shared types and constants of the Pearson correlation engine.
`default_nettype none
package pce_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PAIRS   = 255;
    localparam int COUNT_BITS  = 8;
    localparam int SUM_BITS    = 24;
    localparam int SQ_BITS     = 40;
    localparam int MUL_BITS    = 49;
    localparam int PROD_BITS   = 2 * MUL_BITS;
    localparam int DIFF_BITS   = 50;
    localparam int REM_BITS    = 128;
    localparam int Q_BITS      = 31;
    localparam int ROOT_BITS   = 32;
    localparam int CORR_BITS   = 16;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [SUM_BITS-1:0]   sum_a;
        logic [SUM_BITS-1:0]   sum_b;
        logic [SQ_BITS-1:0]    sum_ab;
        logic [SQ_BITS-1:0]    sum_aa;
        logic [SQ_BITS-1:0]    sum_bb;
    } t_sums;

    typedef struct packed {
        logic                start;
        logic [MUL_BITS-1:0] op_a;
        logic [MUL_BITS-1:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] prod;
    } t_mul_rsp;

endpackage
`default_nettype wire

FILE: hdl/pce_front.sv
// Front part: accumulates sample pairs and hands finished sums to the queue.
`default_nettype none
module pce_front
    import pce_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire [SAMPLE_BITS-1:0] i_sample_a,
    input  wire [SAMPLE_BITS-1:0] i_sample_b,
    input  wire                   i_last_sample,
    output logic                  o_push,
    output t_sums                 o_sums
);

    t_sums r_sums;
    t_sums n_sums;

    logic [2*SAMPLE_BITS-1:0] prod_ab;
    logic [2*SAMPLE_BITS-1:0] prod_aa;
    logic [2*SAMPLE_BITS-1:0] prod_bb;

    // Full-width products of the two samples.
    assign prod_ab = i_sample_a * i_sample_b;
    assign prod_aa = i_sample_a * i_sample_a;
    assign prod_bb = i_sample_b * i_sample_b;

    always_comb begin
        n_sums = r_sums;
        if (r_sums.count < COUNT_BITS'(MAX_PAIRS)) begin
            n_sums.count  = r_sums.count + 1'b1;
            n_sums.sum_a  = r_sums.sum_a + SUM_BITS'(i_sample_a);
            n_sums.sum_b  = r_sums.sum_b + SUM_BITS'(i_sample_b);
            n_sums.sum_ab = r_sums.sum_ab + SQ_BITS'(prod_ab);
            n_sums.sum_aa = r_sums.sum_aa + SQ_BITS'(prod_aa);
            n_sums.sum_bb = r_sums.sum_bb + SQ_BITS'(prod_bb);
        end
    end

    assign o_push = i_accept && i_last_sample;
    assign o_sums = n_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (i_accept) begin
            if (i_last_sample) begin
                r_sums <= '0;
            end else begin
                r_sums <= n_sums;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pce_queue.sv
// Two-entry queue of finished sums between the front and back parts.
`default_nettype none
module pce_queue
    import pce_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_sums i_data,
    input  wire   i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_sums o_data
);

    t_sums       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pce_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module pce_mul
    import pce_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int CNT_BITS = $clog2(MUL_BITS + 1);

    logic [PROD_BITS-1:0] r_acc;
    logic [PROD_BITS-1:0] r_a;
    logic [MUL_BITS-1:0]  r_b;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(MUL_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= PROD_BITS'(i_req.op_a);
            r_b   <= i_req.op_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pce_back.sv
// Back part: variance terms, restoring divide, integer root and output word.
`default_nettype none
module pce_back
    import pce_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_empty,
    input  t_sums                i_sums,
    output logic                 o_pop,
    output t_mul_req             o_mul_req,
    input  t_mul_rsp             i_mul_rsp,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [CORR_BITS-1:0] o_correlation,
    output logic                 o_undefined_flag,
    output logic [COUNT_BITS-1:0] o_pair_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_MSTART, S_MWAIT, S_DIV, S_SQRT, S_OUT
    } t_state;

    t_state                 r_state;
    t_sums                  r_sums;
    logic [2:0]             r_step;
    logic [MUL_BITS-1:0]    r_t;
    logic [DIFF_BITS-1:0]   r_num;
    logic [DIFF_BITS-1:0]   r_va;
    logic [DIFF_BITS-1:0]   r_vb;
    logic [MUL_BITS-1:0]    r_an;
    logic [PROD_BITS-1:0]   r_p;
    logic [REM_BITS-1:0]    r_rem;
    logic [REM_BITS-1:0]    r_dsh;
    logic [Q_BITS-1:0]      r_q;
    logic [ROOT_BITS-1:0]   r_op;
    logic [ROOT_BITS-1:0]   r_res;
    logic [ROOT_BITS-1:0]   r_one;
    logic [4:0]             r_cnt;
    logic                   r_bad;
    logic                   r_valid;
    logic [CORR_BITS-1:0]   r_corr;
    logic                   r_flag;
    logic [COUNT_BITS-1:0]  r_pairs;

    logic [DIFF_BITS-1:0]   diff;
    logic [MUL_BITS-1:0]    n_ext;
    logic [ROOT_BITS-1:0]   trial;
    logic [CORR_BITS-1:0]   mag;
    logic [CORR_BITS-1:0]   corr_val;

    assign n_ext = MUL_BITS'(r_sums.count);
    assign diff  = DIFF_BITS'(r_t) - DIFF_BITS'(i_mul_rsp.prod[MUL_BITS-1:0]);
    assign trial = r_res + r_one;
    assign mag   = r_res[CORR_BITS-1:0];

    always_comb begin
        if (r_bad) begin
            corr_val = '0;
        end else if (r_num[DIFF_BITS-1]) begin
            corr_val = CORR_BITS'(0) - mag;
        end else if (mag[CORR_BITS-1]) begin
            corr_val = {1'b0, {(CORR_BITS-1){1'b1}}};
        end else begin
            corr_val = mag;
        end
    end

    always_comb begin
        o_mul_req.start = (r_state == S_MSTART);
        case (r_step)
            3'd0: begin
                o_mul_req.op_a = n_ext;
                o_mul_req.op_b = MUL_BITS'(r_sums.sum_ab);
            end
            3'd1: begin
                o_mul_req.op_a = MUL_BITS'(r_sums.sum_a);
                o_mul_req.op_b = MUL_BITS'(r_sums.sum_b);
            end
            3'd2: begin
                o_mul_req.op_a = n_ext;
                o_mul_req.op_b = MUL_BITS'(r_sums.sum_aa);
            end
            3'd3: begin
                o_mul_req.op_a = MUL_BITS'(r_sums.sum_a);
                o_mul_req.op_b = MUL_BITS'(r_sums.sum_a);
            end
            3'd4: begin
                o_mul_req.op_a = n_ext;
                o_mul_req.op_b = MUL_BITS'(r_sums.sum_bb);
            end
            3'd5: begin
                o_mul_req.op_a = MUL_BITS'(r_sums.sum_b);
                o_mul_req.op_b = MUL_BITS'(r_sums.sum_b);
            end
            3'd6: begin
                o_mul_req.op_a = r_va[MUL_BITS-1:0];
                o_mul_req.op_b = r_vb[MUL_BITS-1:0];
            end
            default: begin
                o_mul_req.op_a = r_an;
                o_mul_req.op_b = r_an;
            end
        endcase
    end

    assign o_pop            = (r_state == S_IDLE) && !i_empty;
    assign o_valid          = r_valid;
    assign o_correlation    = r_corr;
    assign o_undefined_flag = r_flag;
    assign o_pair_count     = r_pairs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_cnt   <= '0;
            r_bad   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && r_state != S_OUT) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_sums  <= i_sums;
                        r_step  <= 3'd0;
                        r_bad   <= 1'b0;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (i_mul_rsp.done) begin
                        r_step <= r_step + 1'b1;
                        case (r_step)
                            3'd0, 3'd2, 3'd4: begin
                                r_t     <= i_mul_rsp.prod[MUL_BITS-1:0];
                                r_state <= S_MSTART;
                            end
                            3'd1: begin
                                r_num   <= diff;
                                r_an    <= diff[DIFF_BITS-1] ? MUL_BITS'(-diff)
                                                             : diff[MUL_BITS-1:0];
                                r_state <= S_MSTART;
                            end
                            3'd3: begin
                                r_va    <= diff;
                                r_state <= S_MSTART;
                            end
                            3'd5: begin
                                r_vb <= diff;
                                // A series with no spread has no defined coefficient.
                                if (r_va[DIFF_BITS-1] || r_va == '0 ||
                                    diff[DIFF_BITS-1] || diff == '0) begin
                                    r_bad   <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_MSTART;
                                end
                            end
                            3'd6: begin
                                r_p     <= i_mul_rsp.prod;
                                r_state <= S_MSTART;
                            end
                            default: begin
                                r_rem   <= REM_BITS'(i_mul_rsp.prod) << 30;
                                r_dsh   <= REM_BITS'(r_p) << (Q_BITS - 1);
                                r_q     <= '0;
                                r_cnt   <= 5'(Q_BITS - 1);
                                r_state <= S_DIV;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[Q_BITS-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[Q_BITS-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_one == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        if (r_op >= trial) begin
                            r_op  <= r_op - trial;
                            r_res <= (r_res >> 1) + r_one;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_one <= r_one >> 2;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall) begin
                        r_valid <= 1'b1;
                        r_corr  <= corr_val;
                        r_flag  <= r_bad;
                        r_pairs <= r_sums.count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The root starts from the quotient as soon as the divide ends.
            if (r_state == S_DIV && r_cnt == 5'd0) begin
                r_op  <= ROOT_BITS'({r_q[Q_BITS-2:0], (r_rem >= r_dsh)});
                r_res <= '0;
                r_one <= ROOT_BITS'(1) << 30;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pearson_correlation_engine.sv
// Top level of the Pearson correlation engine: front, queue, multiplier and back.
// Each accepted word carries one sample pair; while the queue is not full, the
// front takes one word per clock cycle into exact sums of both series, their
// products and squares and a pair count; pairs past the 255th are dropped. The
// word marked last hands its sums to a two-entry queue, and the back part then
// works out the coefficient (n*Sab - Sa*Sb) / sqrt(Va*Vb) in signed Q1.15,
// truncated toward zero and saturated just below +1, or raises the undefined
// flag with a zero coefficient when a series has no spread. The back part forms
// its products in turn in its shared one-bit-per-cycle multiplier and then runs
// the restoring divide and the integer root; meanwhile the front keeps loading
// the next fingerprint and only stalls when two finished fingerprints already
// wait in the queue.
`default_nettype none
module pearson_correlation_engine
    import pce_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [SAMPLE_BITS-1:0] i_sample_a,
    input  wire  [SAMPLE_BITS-1:0] i_sample_b,
    input  wire                    i_last_sample,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [CORR_BITS-1:0]   o_correlation,
    output logic                   o_undefined_flag,
    output logic [COUNT_BITS-1:0]  o_pair_count
);

    logic     accept;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    t_sums    front_sums;
    t_sums    queue_sums;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    // A full queue holds off new words; the sums are then frozen.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    pce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_last_sample (i_last_sample),
        .o_push        (push),
        .o_sums        (front_sums)
    );

    pce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_sums),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (queue_sums)
    );

    pce_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    pce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_sums           (queue_sums),
        .o_pop            (pop),
        .o_mul_req        (mul_req),
        .i_mul_rsp        (mul_rsp),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_correlation    (o_correlation),
        .o_undefined_flag (o_undefined_flag),
        .o_pair_count     (o_pair_count)
    );

endmodule
`default_nettype wire
